// ===== rtl/twg_pkg.sv =====
package twg_pkg;

    localparam int unsigned ERR_W    = 16;
    localparam int unsigned GAIN_W   = 16;
    localparam int unsigned STEP_W   = 15;
    localparam int unsigned SQ_W     = 32;
    localparam int unsigned SUM_W    = 48;
    localparam int unsigned WIN_W    = 8;
    localparam int unsigned COUNT_W  = 9;
    localparam int unsigned IDX_W    = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned NUM_GAINS  = 3;

    typedef logic signed [GAIN_W-1:0] t_gain;
    typedef logic [STEP_W-1:0]        t_step;
    typedef logic [SQ_W-1:0]          t_sq;
    typedef logic [SUM_W-1:0]         t_sum;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef t_gain [NUM_GAINS-1:0]    t_gain_arr;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TRIAL_WINDOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TOLERANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_KP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_KI     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_KD     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_STEP   = 3'd5;

    // Result word handed from the tuning core to the top level.
    typedef struct packed {
        t_gain_arr gains;
        logic      restart;
        logic      done;
        t_idx      index;
        t_sum      best;
    } t_result;

endpackage

// ===== rtl/twg_sq_stage.sv =====
module twg_sq_stage (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic signed [twg_pkg::ERR_W-1:0]   i_error,
    input  logic                               i_advance,
    output logic                               o_stall,
    output logic                               o_valid,
    output twg_pkg::t_sq                       o_sq
);
    import twg_pkg::*;

    logic  r_valid;
    t_sq   r_sq;
    logic  load;
    logic signed [2*ERR_W-1:0] product;

    assign o_stall = r_valid && !i_advance;
    assign load    = i_valid && !o_stall;
    assign product = i_error * i_error;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    // The square of a sample is never negative, so its bits are taken as unsigned.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_sq <= t_sq'(product);
        end
    end

    assign o_valid = r_valid;
    assign o_sq    = r_sq;

endmodule

// ===== rtl/twg_core.sv =====
module twg_core #(
    parameter int unsigned GAIN_COUNT = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [twg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [twg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_fire,
    input  twg_pkg::t_sq                      i_sq,
    output twg_pkg::t_result                  o_result
);
    import twg_pkg::*;

    typedef enum logic [2:0] {
        PH_BASE = 3'b001,
        PH_TUNE = 3'b010,
        PH_DONE = 3'b100
    } t_phase;

    typedef enum logic [2:0] {
        SP_RAISE   = 3'b001,
        SP_ASCEND  = 3'b010,
        SP_DESCEND = 3'b100
    } t_sub;

    localparam t_sum  SUM_MAX   = '1;
    localparam t_step STEP_MAX  = '1;
    localparam logic [15:0] DIV10_MUL = 16'd52429;   // ceil(2^19 / 10)
    localparam t_idx  IDX_LAST  = t_idx'(GAIN_COUNT - 1);

    // floor(s / 10) by reciprocal multiply, exact for every 15-bit s.
    function automatic logic [11:0] div10(input t_step s);
        logic [30:0] prod;
        prod = {16'd0, s} * {15'd0, DIV10_MUL};
        return prod[30:19];
    endfunction

    function automatic t_step grow(input t_step s);
        logic [11:0]      q;
        logic [STEP_W:0]  v;
        q = div10(s);
        v = {1'b0, s} + {4'd0, q};
        return v[STEP_W] ? STEP_MAX : v[STEP_W-1:0];
    endfunction

    // floor(9s/10) = s - ceil(s/10)
    function automatic t_step shrink(input t_step s);
        logic [11:0] q;
        t_step       tens;
        logic        rem_nz;
        q      = div10(s);
        tens   = (t_step'(q) << 3) + (t_step'(q) << 1);
        rem_nz = (s != tens);
        return s - t_step'(q) - t_step'(rem_nz);
    endfunction

    function automatic t_gain clamp(input logic signed [GAIN_W+1:0] v);
        if (v > 18'sd32767) begin
            return 16'sh7fff;
        end else if (v < -18'sd32768) begin
            return 16'sh8000;
        end
        return t_gain'(v);
    endfunction

    // Configuration registers.
    logic [WIN_W-1:0] r_window,    n_window;
    t_step            r_tolerance, n_tolerance;
    t_gain            r_init_kp,   n_init_kp;
    t_gain            r_init_ki,   n_init_ki;
    t_gain            r_init_kd,   n_init_kd;
    t_step            r_init_step, n_init_step;

    // Tuning state.
    t_phase               r_phase,   n_phase;
    t_sub                 r_sub,     n_sub;
    logic [COUNT_W-1:0]   r_count,   n_count;
    t_sum                 r_sum,     n_sum;
    t_sum                 r_best,    n_best;
    t_gain_arr            r_gain,    n_gain;
    t_step [NUM_GAINS-1:0] r_step,   n_step;
    t_idx                 r_idx,     n_idx;
    logic                 r_restart, n_restart;

    logic                 cfg_hit;
    logic [COUNT_W-1:0]   count_inc;
    logic                 in_second_half;
    logic                 trial_end;
    logic [SUM_W:0]       sum_add;
    t_sum                 sum_run;
    logic                 better;
    logic [STEP_W+1:0]    step_total;
    t_gain                gain_k;
    t_step                step_k;
    t_idx                 idx_next;
    t_gain                gain_up;
    t_gain                gain_down2;

    always_comb begin
        n_window    = r_window;
        n_tolerance = r_tolerance;
        n_init_kp   = r_init_kp;
        n_init_ki   = r_init_ki;
        n_init_kd   = r_init_kd;
        n_init_step = r_init_step;
        cfg_hit     = 1'b1;
        unique case (i_cfg_index)
            CFG_TRIAL_WINDOW:   n_window    = i_cfg_data[WIN_W-1:0];
            CFG_STEP_TOLERANCE: n_tolerance = i_cfg_data[STEP_W-1:0];
            CFG_INITIAL_KP:     n_init_kp   = t_gain'(i_cfg_data);
            CFG_INITIAL_KI:     n_init_ki   = t_gain'(i_cfg_data);
            CFG_INITIAL_KD:     n_init_kd   = t_gain'(i_cfg_data);
            CFG_INITIAL_STEP:   n_init_step = i_cfg_data[STEP_W-1:0];
            default:            cfg_hit     = 1'b0;
        endcase
    end

    // Per-sample trial bookkeeping.
    assign count_inc      = r_count + 1'b1;
    assign in_second_half = count_inc >= {1'b0, r_window};
    assign trial_end      = count_inc >= {r_window, 1'b0};
    assign sum_add        = {1'b0, r_sum} + {{(SUM_W-SQ_W+1){1'b0}}, i_sq};
    assign sum_run        = !in_second_half ? r_sum :
                            (sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0]);
    assign better         = sum_run < r_best;
    assign idx_next       = (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;

    always_comb begin
        step_total = '0;
        gain_k     = r_gain[0];
        step_k     = r_step[0];
        for (int i = 0; i < NUM_GAINS; i++) begin
            if (i < GAIN_COUNT) begin
                step_total = step_total + {2'b00, r_step[i]};
            end
            if (r_idx == t_idx'(i)) begin
                gain_k = r_gain[i];
                step_k = r_step[i];
            end
        end
    end

    assign gain_up    = clamp({{2{gain_k[GAIN_W-1]}}, gain_k} + {3'b000, step_k});
    assign gain_down2 = clamp({{2{gain_k[GAIN_W-1]}}, gain_k} - {2'b00, step_k, 1'b0});

    always_comb begin
        n_phase   = r_phase;
        n_sub     = r_sub;
        n_count   = r_count;
        n_sum     = r_sum;
        n_best    = r_best;
        n_gain    = r_gain;
        n_step    = r_step;
        n_idx     = r_idx;
        n_restart = r_restart;

        if (i_cfg_we) begin
            // Before the baseline trial ends, new start values take effect at once.
            if (cfg_hit && r_phase == PH_BASE) begin
                n_gain[0] = n_init_kp;
                n_gain[1] = n_init_ki;
                n_gain[2] = n_init_kd;
                for (int i = 0; i < NUM_GAINS; i++) begin
                    n_step[i] = n_init_step;
                end
            end
        end else if (i_fire) begin
            n_restart = 1'b0;
            unique case (r_phase)
                PH_BASE: begin
                    n_count = count_inc;
                    n_sum   = sum_run;
                    if (trial_end) begin
                        n_best    = sum_run;
                        n_restart = 1'b1;
                        n_count   = '0;
                        n_sum     = '0;
                        n_phase   = PH_TUNE;
                    end
                end
                PH_TUNE: begin
                    if (step_total <= {2'b00, r_tolerance}) begin
                        n_restart = 1'b1;
                        n_phase   = PH_DONE;
                    end else begin
                        unique case (r_sub)
                            SP_ASCEND: begin
                                n_count = count_inc;
                                n_sum   = sum_run;
                                if (trial_end) begin
                                    n_restart = 1'b1;
                                    n_count   = '0;
                                    n_sum     = '0;
                                    for (int i = 0; i < NUM_GAINS; i++) begin
                                        if (r_idx == t_idx'(i)) begin
                                            if (better) begin
                                                n_step[i] = grow(step_k);
                                            end else begin
                                                n_gain[i] = gain_down2;
                                            end
                                        end
                                    end
                                    if (better) begin
                                        n_best = sum_run;
                                        n_idx  = idx_next;
                                        n_sub  = SP_RAISE;
                                    end else begin
                                        n_sub  = SP_DESCEND;
                                    end
                                end
                            end
                            SP_DESCEND: begin
                                n_count = count_inc;
                                n_sum   = sum_run;
                                if (trial_end) begin
                                    n_restart = 1'b1;
                                    n_count   = '0;
                                    n_sum     = '0;
                                    for (int i = 0; i < NUM_GAINS; i++) begin
                                        if (r_idx == t_idx'(i)) begin
                                            if (better) begin
                                                n_step[i] = grow(step_k);
                                            end else begin
                                                n_gain[i] = gain_up;
                                                n_step[i] = shrink(step_k);
                                            end
                                        end
                                    end
                                    if (better) begin
                                        n_best = sum_run;
                                    end
                                    n_idx = idx_next;
                                    n_sub = SP_RAISE;
                                end
                            end
                            default: begin
                                // Raise: the sample of this word is not summed.
                                for (int i = 0; i < NUM_GAINS; i++) begin
                                    if (r_idx == t_idx'(i)) begin
                                        n_gain[i] = gain_up;
                                    end
                                end
                                n_restart = 1'b1;
                                n_count   = '0;
                                n_sum     = '0;
                                n_sub     = SP_ASCEND;
                            end
                        endcase
                    end
                end
                default: begin
                    // Done: state is frozen.
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= 8'd200;
            r_tolerance <= 15'd82;
            r_init_kp   <= 16'sd819;
            r_init_ki   <= 16'sd0;
            r_init_kd   <= 16'sd819;
            r_init_step <= 15'd410;
            r_phase     <= PH_BASE;
            r_sub       <= SP_RAISE;
            r_count     <= '0;
            r_sum       <= '0;
            r_best      <= '0;
            r_gain[0]   <= 16'sd819;
            r_gain[1]   <= 16'sd0;
            r_gain[2]   <= 16'sd819;
            for (int i = 0; i < NUM_GAINS; i++) begin
                r_step[i] <= 15'd410;
            end
            r_idx       <= '0;
            r_restart   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window    <= n_window;
                r_tolerance <= n_tolerance;
                r_init_kp   <= n_init_kp;
                r_init_ki   <= n_init_ki;
                r_init_kd   <= n_init_kd;
                r_init_step <= n_init_step;
            end
            r_phase   <= n_phase;
            r_sub     <= n_sub;
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_best    <= n_best;
            r_gain    <= n_gain;
            r_step    <= n_step;
            r_idx     <= n_idx;
            r_restart <= n_restart;
        end
    end

    assign o_result.gains   = r_gain;
    assign o_result.restart = r_restart;
    assign o_result.done    = (r_phase != PH_BASE) && (r_phase != PH_TUNE);
    assign o_result.index   = r_idx;
    assign o_result.best    = r_best;

endmodule

// ===== rtl/twiddle_gain_tuner.sv =====
// Twiddle gain tuner. Each input word carries one signed Q4.12 tracking-error
// sample, and each accepted word yields exactly one result word holding the
// three PID gains after that sample, a one-word restart pulse that tells the
// controller and plant to start a new trial, the done flag, the index of the
// gain under test and the best Q24.24 squared-error sum so far. A trial spans
// twice trial_window samples, and only the squares from sample trial_window
// onward are summed. After a baseline trial, each gain in turn is raised by
// its step and, if that fails, lowered by twice the step and, if that fails
// too, restored, with the step growing by 1.1 on success and shrinking by 0.9
// when both fail, until the sum of the steps is at most step_tolerance; after
// that the state is frozen. Throughput is one word per clock while the result
// side does not stall. A word passes the square register, which holds the
// square of the sample, and then the tuner state itself, whose add, saturate
// and compare close the loop from one sample to the next. The output fields
// are read straight from that state, so a stalled result holds its value
// while the input side can still take one word into an empty square register.
// Configuration may be written only while no word is in flight; a write to
// any mapped register during the baseline also reloads working gains and steps.
module twiddle_gain_tuner #(
    parameter int unsigned GAIN_COUNT = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_cfg_we,
    input  logic [twg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [twg_pkg::CFG_DATA_W-1:0]    i_cfg_data,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [twg_pkg::ERR_W-1:0]  i_track_error,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [twg_pkg::GAIN_W-1:0] o_gain_p,
    output logic signed [twg_pkg::GAIN_W-1:0] o_gain_i,
    output logic signed [twg_pkg::GAIN_W-1:0] o_gain_d,
    output logic                              o_restart,
    output logic                              o_tuning_done,
    output logic [twg_pkg::IDX_W-1:0]         o_tuned_index,
    output logic [twg_pkg::SUM_W-1:0]         o_best_sum
);
    import twg_pkg::*;

    logic    r_out_valid;
    logic    advance;
    logic    sq_valid;
    t_sq     sq;
    logic    fire;
    t_result result;

    // The result register can take a new word when it is empty or being read.
    assign advance = !r_out_valid || !i_out_stall;
    assign fire    = sq_valid && advance;

    twg_sq_stage u_sq_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_error   (i_track_error),
        .i_advance (advance),
        .o_stall   (o_in_stall),
        .o_valid   (sq_valid),
        .o_sq      (sq)
    );

    twg_core #(
        .GAIN_COUNT (GAIN_COUNT)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_sq        (sq),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= sq_valid;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_gain_p      = result.gains[0];
    assign o_gain_i      = result.gains[1];
    assign o_gain_d      = result.gains[2];
    assign o_restart     = result.restart;
    assign o_tuning_done = result.done;
    assign o_tuned_index = result.index;
    assign o_best_sum    = result.best;

endmodule

// ===== verif/twiddle_gain_tuner_tb.sv =====
`timescale 1ns / 100ps

// This bench drives error samples into the twiddle gain tuner and checks every
// result word against a predictor of the tuner. The predictor keeps its own
// copy of the configuration and the tuning state. Reset is applied once, at
// the start. Tuning can only end once, so the run is laid out as a single long
// tuning session that is steered through several register settings. At the
// end the step tolerance is raised so that the session closes.
module twiddle_gain_tuner_tb;
    import twg_pkg::*;

    localparam int TUNED_GAINS = 3;
    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 4;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PROBE_ROWS = 23;
    localparam int RELOAD_ROW = 3;

    // Index 7 decodes to no register, so a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

    typedef enum logic [1:0] {PH_BASELINE, PH_TUNING, PH_FINISHED} t_tune_phase;
    typedef enum logic [1:0] {STEP_RAISE, STEP_ASCEND, STEP_DESCEND} t_trial_step;

    typedef struct {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_reg_write;

    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic                    typed;
        t_result                 want;
    } t_probe_row;

    // Results that can be read straight off the reset values and extremes.
    // Gains are keyed by index: 0 is p, 1 is i and 2 is d.
    localparam t_result AT_RESET = '{
        gains: '{0: 16'sd819, 1: 16'sd0, 2: 16'sd819},
        restart: 1'b0, done: 1'b0, index: '0, best: '0};
    // The baseline closes on a full-scale negative sample, which alone is summed.
    localparam t_result BASE_END = '{
        gains: '{0: 16'sh7FFF, 1: 16'sh8000, 2: 16'sh0000},
        restart: 1'b1, done: 1'b0, index: '0, best: 48'h0000_4000_0000};
    // Raising the largest gain by the largest step saturates it.
    localparam t_result RAISE_CLAMP = BASE_END;
    localparam t_result NOT_TYPED = '0;

    // Directed samples. The first three run at the reset settings, then the
    // start point is reloaded during the baseline and the rest step through a
    // raise, a failed ascent, a successful descent and further trials.
    localparam t_probe_row PROBE [PROBE_ROWS] = '{
        '{16'sh0000, 1'b1, AT_RESET},
        '{16'sh7FFF, 1'b1, AT_RESET},
        '{16'sh8000, 1'b1, AT_RESET},
        '{16'sh8000, 1'b1, BASE_END},
        '{16'sh0001, 1'b1, RAISE_CLAMP},
        '{16'shFFFF, 1'b0, NOT_TYPED},
        '{16'sh0000, 1'b0, NOT_TYPED},
        '{16'sh7FFF, 1'b0, NOT_TYPED},
        '{16'sh8000, 1'b0, NOT_TYPED},
        '{16'sh0001, 1'b0, NOT_TYPED},
        '{16'sh5555, 1'b0, NOT_TYPED},
        '{16'shAAAA, 1'b0, NOT_TYPED},
        '{16'sh00FF, 1'b0, NOT_TYPED},
        '{16'shFF00, 1'b0, NOT_TYPED},
        '{16'shFF00, 1'b0, NOT_TYPED},
        '{16'sh4000, 1'b0, NOT_TYPED},
        '{16'sh0000, 1'b0, NOT_TYPED},
        '{16'sh2000, 1'b0, NOT_TYPED},
        '{16'sh1234, 1'b0, NOT_TYPED},
        '{16'sh8000, 1'b0, NOT_TYPED},
        '{16'sh7FFF, 1'b0, NOT_TYPED},
        '{16'sh0010, 1'b0, NOT_TYPED},
        '{16'shFFF0, 1'b0, NOT_TYPED}
    };

    // Signals driven into the block. All start at known values.
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic signed [ERR_W-1:0] track_error = '0;
    logic                  out_stall = 1'b0;

    // Outputs of the block.
    logic                  in_stall;
    logic                  out_valid;
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic                  restart;
    logic                  tuning_done;
    logic [IDX_W-1:0]      tuned_index;
    logic [SUM_W-1:0]      best_sum;

    // A directed word can carry its own expected result alongside it.
    logic                  row_typed = 1'b0;
    t_result               row_expect = '0;

    // Pacing shared by both sides: quiet turns idling off for a whole phase,
    // and hold_request asks the result side for one long hold-off.
    bit quiet = 1'b0;
    bit hold_request = 1'b0;
    int err_shift = 0;

    // Predicted tuner: configuration copy.
    logic [WIN_W-1:0]  cfg_window;
    logic [STEP_W-1:0] cfg_tol;
    t_gain             init_gain [TUNED_GAINS];
    t_step             init_step;

    // Predicted tuner: working state.
    t_tune_phase       tuner_ph;
    t_trial_step       tuner_sub;
    logic [COUNT_W-1:0] trial_cnt;
    t_sum              err_acc;
    t_sum              best_acc;
    t_gain             work_gain [TUNED_GAINS];
    t_step             work_step [TUNED_GAINS];
    t_idx              gain_sel;

    // Expected result words, oldest first.
    t_result tuner_reports [$];

    int fails = 0;
    int samples_taken = 0;
    int reports_checked = 0;
    int restarts_seen = 0;
    int cycles = 0;

    twiddle_gain_tuner #(
        .GAIN_COUNT(TUNED_GAINS)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_track_error(track_error),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_gain_p(gain_p),
        .o_gain_i(gain_i),
        .o_gain_d(gain_d),
        .o_restart(restart),
        .o_tuning_done(tuning_done),
        .o_tuned_index(tuned_index),
        .o_best_sum(best_sum)
    );

    always begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    function automatic t_gain clamp_gain(input int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return t_gain'(v);
    endfunction

    function automatic t_step grow_step(input t_step s);
        int v;
        v = (int'(s) * 11) / 10;
        return (v > 32767) ? 15'h7FFF : t_step'(v);
    endfunction

    function automatic t_step shrink_step(input t_step s);
        return t_step'((int'(s) * 9) / 10);
    endfunction

    function automatic t_idx following_gain(input t_idx g);
        return t_idx'((int'(g) + 1) % TUNED_GAINS);
    endfunction

    function automatic void load_start_point();
        int g;
        for (g = 0; g < TUNED_GAINS; g++) begin
            work_gain[g] = init_gain[g];
            work_step[g] = init_step;
        end
    endfunction

    function automatic void open_trial();
        trial_cnt = '0;
        err_acc = '0;
    endfunction

    // Counts one sample, adds its square from the second half of the trial
    // on, and tells whether the trial is now complete.
    function automatic bit absorb_sample(input t_sq sq);
        logic [SUM_W:0] widened;
        trial_cnt = trial_cnt + 1'b1;
        if (trial_cnt >= {1'b0, cfg_window}) begin
            widened = err_acc + sq;
            err_acc = widened[SUM_W] ? '1 : widened[SUM_W-1:0];
        end
        return {1'b0, trial_cnt} >= {1'b0, cfg_window, 1'b0};
    endfunction

    task automatic tune_on_sample(input logic signed [ERR_W-1:0] e, output t_result r);
        t_sq  sq;
        logic pulse;
        int   k;
        int   g;
        int   step_total;
        sq = t_sq'(int'(e) * int'(e));
        pulse = 1'b0;
        k = int'(gain_sel);
        step_total = 0;
        case (tuner_ph)
            PH_BASELINE: begin
                if (absorb_sample(sq)) begin
                    best_acc = err_acc;
                    pulse = 1'b1;
                    open_trial();
                    tuner_ph = PH_TUNING;
                end
            end
            PH_TUNING: begin
                for (g = 0; g < TUNED_GAINS; g++) step_total += int'(work_step[g]);
                if (step_total <= int'(cfg_tol)) begin
                    pulse = 1'b1;
                    tuner_ph = PH_FINISHED;
                end else begin
                    case (tuner_sub)
                        STEP_ASCEND: begin
                            if (absorb_sample(sq)) begin
                                pulse = 1'b1;
                                if (err_acc < best_acc) begin
                                    best_acc = err_acc;
                                    work_step[k] = grow_step(work_step[k]);
                                    gain_sel = following_gain(gain_sel);
                                    tuner_sub = STEP_RAISE;
                                end else begin
                                    work_gain[k] = clamp_gain(int'(work_gain[k])
                                                              - 2 * int'(work_step[k]));
                                    tuner_sub = STEP_DESCEND;
                                end
                                open_trial();
                            end
                        end
                        STEP_DESCEND: begin
                            if (absorb_sample(sq)) begin
                                if (err_acc < best_acc) begin
                                    best_acc = err_acc;
                                    work_step[k] = grow_step(work_step[k]);
                                end else begin
                                    work_gain[k] = clamp_gain(int'(work_gain[k])
                                                              + int'(work_step[k]));
                                    work_step[k] = shrink_step(work_step[k]);
                                end
                                pulse = 1'b1;
                                open_trial();
                                tuner_sub = STEP_RAISE;
                                gain_sel = following_gain(gain_sel);
                            end
                        end
                        default: begin
                            // The raising word only moves the gain; its sample is dropped.
                            work_gain[k] = clamp_gain(int'(work_gain[k]) + int'(work_step[k]));
                            pulse = 1'b1;
                            open_trial();
                            tuner_sub = STEP_ASCEND;
                        end
                    endcase
                end
            end
            default: ;
        endcase
        r.gains[0] = work_gain[0];
        r.gains[1] = work_gain[1];
        r.gains[2] = work_gain[2];
        r.restart = pulse;
        r.done = (tuner_ph == PH_FINISHED);
        r.index = gain_sel;
        r.best = best_acc;
    endtask

    // A write to a start register during the baseline also reloads the working
    // gains and steps; an unmapped index changes nothing at all.
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] d);
        bit mapped;
        mapped = 1'b1;
        case (idx)
            CFG_TRIAL_WINDOW:   cfg_window = d[WIN_W-1:0];
            CFG_STEP_TOLERANCE: cfg_tol = d[STEP_W-1:0];
            CFG_INITIAL_KP:     init_gain[0] = d;
            CFG_INITIAL_KI:     init_gain[1] = d;
            CFG_INITIAL_KD:     init_gain[2] = d;
            CFG_INITIAL_STEP:   init_step = d[STEP_W-1:0];
            default:            mapped = 1'b0;
        endcase
        if (mapped && tuner_ph == PH_BASELINE) load_start_point();
    endfunction

    // ---------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------

    // Offers one sample word after a random gap and returns at the edge that
    // takes it. Valid stays high into the next word when that word has no gap.
    task automatic send_error(input logic signed [ERR_W-1:0] e, input logic typed,
                              input t_result want);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        track_error <= e;
        row_typed <= typed;
        row_expect <= want;
        do @(posedge clk); while (in_stall !== 1'b0);
    endtask

    // Waits until every expected word has come back, then lets the block settle.
    // The first edge lets the word taken at the last edge reach the queue.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tuner_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes a batch of registers on back-to-back edges.
    task automatic program_regs(input t_reg_write batch [$]);
        int n;
        for (n = 0; n < batch.size(); n++) begin
            cfg_we <= 1'b1;
            cfg_index <= batch[n].idx;
            cfg_data <= batch[n].data;
            @(posedge clk);
            apply_reg(batch[n].idx, batch[n].data);
        end
        cfg_we <= 1'b0;
    endtask

    // Random samples. Most words come in runs of similar size, so that trial
    // sums swing up and down and both outcomes of a trial keep occurring.
    // Loud words are full-scale noise. With close_out the phase ends a few
    // words after tuning has finished.
    task automatic run_random(input int count, input bit loud, input bit close_out);
        int n;
        int after;
        logic signed [ERR_W-1:0] e;
        after = 0;
        for (n = 0; n < count; n++) begin
            if (close_out && tuner_ph == PH_FINISHED) after++;
            if (after > 8) break;
            if (loud) begin
                e = 16'($urandom);
            end else begin
                if ($urandom_range(0, 7) == 0) err_shift = $urandom_range(0, 13);
                if ($urandom_range(0, 15) == 0)
                    e = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                else
                    e = $signed(16'($urandom)) >>> err_shift;
            end
            send_error(e, 1'b0, NOT_TYPED);
        end
    endtask

    // ---------------------------------------------------------------------
    // Monitors
    // ---------------------------------------------------------------------

    // Every word the block takes is run through the predictor. A directed word
    // with a typed result uses that one in place of the predicted result.
    always @(posedge clk) begin : take_samples
        t_result r;
        if (rst_n && in_valid && in_stall === 1'b0) begin
            tune_on_sample(track_error, r);
            if (row_typed) r = row_expect;
            tuner_reports.push_back(r);
            samples_taken++;
        end
    end

    always @(posedge clk) begin : check_reports
        t_result want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
            if (tuner_reports.size() == 0) begin
                $error("result word arrived with nothing expected");
                fails++;
            end else begin
                want = tuner_reports.pop_front();
                reports_checked++;
                if (restart === 1'b1) restarts_seen++;
                if (gain_p !== want.gains[0]) begin
                    $error("gain_p: expected %0d, got %0d", want.gains[0], gain_p);
                    fails++;
                end
                if (gain_i !== want.gains[1]) begin
                    $error("gain_i: expected %0d, got %0d", want.gains[1], gain_i);
                    fails++;
                end
                if (gain_d !== want.gains[2]) begin
                    $error("gain_d: expected %0d, got %0d", want.gains[2], gain_d);
                    fails++;
                end
                if (restart !== want.restart) begin
                    $error("restart: expected %0b, got %0b", want.restart, restart);
                    fails++;
                end
                if (tuning_done !== want.done) begin
                    $error("tuning_done: expected %0b, got %0b", want.done, tuning_done);
                    fails++;
                end
                if (tuned_index !== want.index) begin
                    $error("tuned_index: expected %0d, got %0d", want.index, tuned_index);
                    fails++;
                end
                if (best_sum !== want.best) begin
                    $error("best_sum: expected %0h, got %0h", want.best, best_sum);
                    fails++;
                end
            end
        end
    end

    // Result side: a random stall before each word, and once in the run a long
    // hold-off so that the block fills up and stalls its input.
    initial begin : pace_results
        int gap;
        int held;
        forever begin
            if (hold_request) begin
                out_stall <= 1'b1;
                held = 0;
                while (held < LONG_HOLD) begin
                    @(posedge clk);
                    held++;
                end
                hold_request = 1'b0;
            end
            gap = quiet ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    // Watchdog: the run must end well inside this many cycles.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------

    initial begin : stimulus
        t_reg_write regs [$];
        int r;
        int ph;

        // Predictor at its reset values.
        cfg_window = 8'd200;
        cfg_tol = 15'd82;
        init_gain[0] = 16'sd819;
        init_gain[1] = 16'sd0;
        init_gain[2] = 16'sd819;
        init_step = 15'd410;
        tuner_ph = PH_BASELINE;
        tuner_sub = STEP_RAISE;
        gain_sel = '0;
        best_acc = '0;
        open_trial();
        load_start_point();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Before the reload row the baseline is still open, so
        // every start register written there also reloads the working set.
        // The upper data bits of the window, tolerance and step writes are
        // set on purpose to show that they are dropped.
        for (r = 0; r < PROBE_ROWS; r++) begin
            if (r == RELOAD_ROW) begin
                wait_idle();
                regs.delete();
                regs.push_back('{CFG_INITIAL_KP, 16'h7FFF});
                regs.push_back('{CFG_INITIAL_KI, 16'h8000});
                regs.push_back('{CFG_INITIAL_KD, 16'h0000});
                regs.push_back('{CFG_INITIAL_STEP, 16'hFFFF});
                regs.push_back('{CFG_STEP_TOLERANCE, 16'h8000});
                regs.push_back('{CFG_TRIAL_WINDOW, 16'hAB02});
                regs.push_back('{CFG_UNMAPPED, 16'hFFFF});
                program_regs(regs);
            end
            send_error(PROBE[r].err, PROBE[r].typed, PROBE[r].want);
        end

        // Single-sample half trials.
        wait_idle();
        regs.delete();
        regs.push_back('{CFG_TRIAL_WINDOW, 16'h0001});
        program_regs(regs);
        run_random(200, 1'b0, 1'b0);

        // A zero window makes every sample a whole trial; no idling here.
        wait_idle();
        regs.delete();
        regs.push_back('{CFG_TRIAL_WINDOW, 16'h0000});
        program_regs(regs);
        quiet = 1'b1;
        run_random(100, 1'b0, 1'b0);
        quiet = 1'b0;

        // The widest window, long enough for one full trial, with the result
        // side holding off for a long stretch near the start.
        wait_idle();
        regs.delete();
        regs.push_back('{CFG_TRIAL_WINDOW, 16'h00FF});
        program_regs(regs);
        hold_request = 1'b1;
        run_random(520, 1'b0, 1'b0);

        // Short random windows and low tolerances. The start registers are
        // rewritten too; past the baseline they must not touch the working set.
        for (ph = 0; ph < 3; ph++) begin
            wait_idle();
            regs.delete();
            regs.push_back('{CFG_TRIAL_WINDOW, 16'($urandom_range(1, 6))});
            regs.push_back('{CFG_STEP_TOLERANCE, 16'($urandom_range(0, 8))});
            regs.push_back('{CFG_INITIAL_KP, 16'($urandom)});
            regs.push_back('{CFG_INITIAL_KI, 16'($urandom)});
            regs.push_back('{CFG_INITIAL_KD, 16'($urandom)});
            regs.push_back('{CFG_INITIAL_STEP, 16'($urandom)});
            program_regs(regs);
            quiet = ($urandom_range(0, 3) == 0);
            run_random(110, 1'b0, 1'b0);
            quiet = 1'b0;
        end

        // Closing phase: the largest tolerance and one-sample trials of loud
        // noise drive the steps down until tuning ends, and a few words after
        // that show the frozen state.
        wait_idle();
        regs.delete();
        regs.push_back('{CFG_STEP_TOLERANCE, 16'h7FFF});
        regs.push_back('{CFG_TRIAL_WINDOW, 16'h0000});
        program_regs(regs);
        run_random(300, 1'b1, 1'b1);

        wait_idle();
        $display("Checked %0d result words for %0d sample words, %0d with a trial restart.",
                 reports_checked, samples_taken, restarts_seen);
        $display("Windows of 0, 1, 2, 255 and short random ones were run; tuning %s.",
                 (tuner_ph == PH_FINISHED) ? "ran to its end" : "was still open");
        if (fails == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/twg_pkg.sv
rtl/twg_sq_stage.sv
rtl/twg_core.sv
rtl/twiddle_gain_tuner.sv
verif/twiddle_gain_tuner_tb.sv
